@@ design/xcr_pkg.sv @@
// xcr_pkg: shared types and constants of the xmodem checksum receiver
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package xcr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_FRAMING = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
    logic       is_soh;
    logic       is_eot;
    logic       is_can;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       block_commit;
    logic       session_done;
    logic [1:0] session_status;
  } result_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CAN   = 2'd1;
  localparam logic [1:0] ST_RXERR = 2'd2;
  localparam logic [1:0] ST_TMOUT = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam int ERR_KINDS = 6;
  localparam logic [CFG_IDX_W-1:0] ERR_CHECKSUM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] ERR_SEQUENCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] ERR_PROTOCOL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] ERR_UNDERRUN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] ERR_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] ERR_STOP     = 3'd5;

  localparam logic [7:0] LIMIT_RESET = 8'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

endpackage

`default_nettype wire

@@ design/xmodem_checksum_receiver.sv @@
// xmodem_checksum_receiver: top level of the xmodem 8-bit checksum receiver
// depends on xcr_pkg, xcr_front, xcr_queue and xcr_back
//
// usage: the line side presents one transaction per cycle on in_cmd/in_rx_byte
// while in_stall is low (byte, window timeout, framing error, start session). the
// block answers on out_ with at most one result per input: a tentative payload
// byte, or a reply character and/or a session end, with a commit flag. header
// bytes, and all but a start while no session is open, give no result.
// an input passes the front register, the queue and then the result register.
// throughput: one transaction per cycle while out_ is not stalled, set by the
// state update in the back end; the front register and a four-entry queue
// decouple the two sides.
// when the receiver stalls out_, the result register holds and the queue fills;
// in_stall rises only once the queue and the front register are both full.
// reset (rst_n low, synchronous) empties the pipeline, closes any session and
// sets all six error limits to 10. the limits are written through cfg_; the user
// must write them only while the block is idle, which the block does not enforce.
`default_nettype none

module xmodem_checksum_receiver #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [xcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_payload_valid,
  output logic [7:0]                         out_payload_byte,
  output logic [6:0]                         out_payload_index,
  output logic                               out_reply_valid,
  output logic [7:0]                         out_reply_byte,
  output logic                               out_block_commit,
  output logic                               out_session_done,
  output logic [1:0]                         out_session_status
);

  xcr_pkg::item_t         push_item, head_item;
  xcr_pkg::queue_status_t q_status;
  xcr_pkg::result_t       res;
  logic                   push, pop;

  xcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_status.full),
    .push      (push),
    .push_item (push_item)
  );

  xcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .status   (q_status)
  );

  xcr_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_status (q_status),
    .item     (head_item),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  assign out_payload_valid  = res.payload_valid;
  assign out_payload_byte   = res.payload_byte;
  assign out_payload_index  = res.payload_index;
  assign out_reply_valid    = res.reply_valid;
  assign out_reply_byte     = res.reply_byte;
  assign out_block_commit   = res.block_commit;
  assign out_session_done   = res.session_done;
  assign out_session_status = res.session_status;

`ifndef SYNTHESIS
  a_payload_xor_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload_valid && (out_reply_valid || out_session_done)))
    else $error("payload result carries reply or session end");

  a_commit_acks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_commit) |->
      (out_reply_valid && out_reply_byte == xcr_pkg::CH_ACK && !out_session_done))
    else $error("commit without ack");

  a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload_valid || out_reply_valid || out_session_done))
    else $error("empty result delivered");

  a_in_stall_needs_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_status.full)
    else $error("input stalled with room in the queue");
`endif

endmodule

`default_nettype wire

@@ design/xcr_front.sv @@
// xcr_front: input register stage that decodes the command and flags lead characters
// depends on xcr_pkg; feeds xcr_queue
`default_nettype none

module xcr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_cmd,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          q_full,
  output logic               push,
  output xcr_pkg::item_t     push_item
);

  logic           fr_valid_r, fr_valid_nxt;
  xcr_pkg::item_t fr_item_r, fr_item_nxt;
  logic           load;

  assign in_stall = fr_valid_r && q_full;
  assign push     = fr_valid_r && !q_full;
  assign load     = !in_stall;
  assign push_item = fr_item_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (load) begin
      fr_valid_nxt        = in_valid;
      fr_item_nxt.op      = xcr_pkg::op_t'(in_cmd);
      fr_item_nxt.rx_byte = in_rx_byte;
      fr_item_nxt.is_soh  = (in_rx_byte == xcr_pkg::CH_SOH);
      fr_item_nxt.is_eot  = (in_rx_byte == xcr_pkg::CH_EOT);
      fr_item_nxt.is_can  = (in_rx_byte == xcr_pkg::CH_CAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

endmodule

`default_nettype wire

@@ design/xcr_queue.sv @@
// xcr_queue: short fifo of decoded transactions between front and back
// depends on xcr_pkg
`default_nettype none

module xcr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire xcr_pkg::item_t  push_item,
  input  wire logic            pop,
  output xcr_pkg::item_t       head_item,
  output xcr_pkg::queue_status_t status
);

  xcr_pkg::item_t mem_r [xcr_pkg::QUEUE_DEPTH];
  logic [xcr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [xcr_pkg::QPTR_W:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign status.full  = (count_r == (xcr_pkg::QPTR_W+1)'(xcr_pkg::QUEUE_DEPTH));
  assign status.valid = (count_r != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ design/xcr_back.sv @@
// xcr_back: session state, window tracking, error counters and result register
// depends on xcr_pkg; drains xcr_queue
`default_nettype none

module xcr_back #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [xcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire xcr_pkg::queue_status_t        q_status,
  input  wire xcr_pkg::item_t                item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output xcr_pkg::result_t                   out_res
);

  localparam int WCW = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [WCW-1:0] POS_LAST_PAY = WCW'(PAYLOAD_BYTES + 2);

  logic                active_r, active_nxt;
  logic [7:0]          exp_r, exp_nxt;
  logic [WCW-1:0]      wc_r, wc_nxt;
  logic                lead_soh_r, lead_soh_nxt;
  logic                lead_eot_r, lead_eot_nxt;
  logic                lead_can_r, lead_can_nxt;
  logic [7:0]          bns_r, bns_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          err_cnt_r [xcr_pkg::ERR_KINDS];
  logic [7:0]          err_cnt_nxt [xcr_pkg::ERR_KINDS];
  logic [7:0]          lim_r [xcr_pkg::ERR_KINDS];
  logic                out_valid_r, out_valid_nxt;
  xcr_pkg::result_t    res_r, res_nxt, res;
  logic                has_res, err_hit, clear_errs;
  logic [xcr_pkg::CFG_IDX_W-1:0] err_kind;
  logic [1:0]          err_status;
  logic [7:0]          err_inc;
  logic [WCW-1:0]      pay_pos;

  assign pop       = q_status.valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign pay_pos   = wc_r - WCW'(3);
  assign err_inc   = err_cnt_r[err_kind] + 8'd1;

  always_comb begin
    active_nxt   = active_r;
    exp_nxt      = exp_r;
    wc_nxt       = wc_r;
    lead_soh_nxt = lead_soh_r;
    lead_eot_nxt = lead_eot_r;
    lead_can_nxt = lead_can_r;
    bns_nxt      = bns_r;
    sum_nxt      = sum_r;
    res          = '0;
    has_res      = 1'b0;
    err_hit      = 1'b0;
    clear_errs   = 1'b0;
    err_kind     = xcr_pkg::ERR_CHECKSUM;
    err_status   = xcr_pkg::ST_RXERR;
    for (int k = 0; k < xcr_pkg::ERR_KINDS; k++) begin
      err_cnt_nxt[k] = err_cnt_r[k];
    end

    if (pop) begin
      if (item.op == xcr_pkg::OP_START) begin
        clear_errs       = 1'b1;
        exp_nxt          = 8'd1;
        lead_soh_nxt     = 1'b0;
        lead_eot_nxt     = 1'b0;
        lead_can_nxt     = 1'b0;
        bns_nxt          = '0;
        wc_nxt           = '0;
        sum_nxt          = '0;
        active_nxt       = 1'b1;
        has_res          = 1'b1;
        res.reply_valid  = 1'b1;
        res.reply_byte   = xcr_pkg::CH_NAK;
      end else if (active_r) begin
        unique case (item.op)
          xcr_pkg::OP_FRAMING: begin
            wc_nxt   = '0;
            sum_nxt  = '0;
            err_hit  = 1'b1;
            err_kind = xcr_pkg::ERR_STOP;
          end
          xcr_pkg::OP_TIMEOUT: begin
            wc_nxt  = '0;
            sum_nxt = '0;
            if (wc_r == WCW'(1)) begin
              if (lead_eot_r || lead_can_r) begin
                has_res            = 1'b1;
                res.reply_valid    = 1'b1;
                res.reply_byte     = xcr_pkg::CH_ACK;
                res.session_done   = 1'b1;
                res.session_status = lead_eot_r ? xcr_pkg::ST_OK : xcr_pkg::ST_CAN;
                active_nxt         = 1'b0;
              end else begin
                err_hit  = 1'b1;
                err_kind = xcr_pkg::ERR_PROTOCOL;
              end
            end else if (wc_r != '0) begin
              err_hit  = 1'b1;
              err_kind = xcr_pkg::ERR_UNDERRUN;
            end else begin
              err_hit    = 1'b1;
              err_kind   = xcr_pkg::ERR_TIMEOUT;
              err_status = xcr_pkg::ST_TMOUT;
            end
          end
          default: begin
            if (wc_r == WCW'(0)) begin
              lead_soh_nxt = item.is_soh;
              lead_eot_nxt = item.is_eot;
              lead_can_nxt = item.is_can;
              wc_nxt       = WCW'(1);
            end else if (wc_r == WCW'(1)) begin
              bns_nxt = item.rx_byte;
              wc_nxt  = WCW'(2);
            end else if (wc_r == WCW'(2)) begin
              wc_nxt = WCW'(3);
            end else if (wc_r <= POS_LAST_PAY) begin
              sum_nxt           = sum_r + item.rx_byte;
              wc_nxt            = wc_r + 1'b1;
              has_res           = 1'b1;
              res.payload_valid = 1'b1;
              res.payload_byte  = item.rx_byte;
              res.payload_index = pay_pos[6:0];
            end else begin
              wc_nxt  = '0;
              sum_nxt = '0;
              if (!lead_soh_r) begin
                err_hit  = 1'b1;
                err_kind = xcr_pkg::ERR_PROTOCOL;
              end else if (bns_r == exp_r) begin
                if (sum_r == item.rx_byte) begin
                  exp_nxt          = exp_r + 8'd1;
                  has_res          = 1'b1;
                  res.block_commit = 1'b1;
                  res.reply_valid  = 1'b1;
                  res.reply_byte   = xcr_pkg::CH_ACK;
                end else begin
                  err_hit  = 1'b1;
                  err_kind = xcr_pkg::ERR_CHECKSUM;
                end
              end else if (bns_r == exp_r - 8'd1) begin
                has_res         = 1'b1;
                res.reply_valid = 1'b1;
                res.reply_byte  = xcr_pkg::CH_ACK;
              end else begin
                err_hit  = 1'b1;
                err_kind = xcr_pkg::ERR_SEQUENCE;
              end
            end
          end
        endcase
      end
    end

    if (clear_errs) begin
      for (int k = 0; k < xcr_pkg::ERR_KINDS; k++) begin
        err_cnt_nxt[k] = '0;
      end
    end

    if (err_hit) begin
      has_res = 1'b1;
      err_cnt_nxt[err_kind] = err_inc;
      if (err_inc == lim_r[err_kind]) begin
        res.session_done   = 1'b1;
        res.session_status = err_status;
        active_nxt         = 1'b0;
      end else begin
        res.reply_valid = 1'b1;
        res.reply_byte  = xcr_pkg::CH_NAK;
      end
    end

    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (pop) begin
      out_valid_nxt = has_res;
      res_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      exp_r       <= 8'd1;
      wc_r        <= '0;
      lead_soh_r  <= 1'b0;
      lead_eot_r  <= 1'b0;
      lead_can_r  <= 1'b0;
      bns_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < xcr_pkg::ERR_KINDS; k++) begin
        err_cnt_r[k] <= '0;
        lim_r[k]     <= xcr_pkg::LIMIT_RESET;
      end
    end else begin
      active_r    <= active_nxt;
      exp_r       <= exp_nxt;
      wc_r        <= wc_nxt;
      lead_soh_r  <= lead_soh_nxt;
      lead_eot_r  <= lead_eot_nxt;
      lead_can_r  <= lead_can_nxt;
      bns_r       <= bns_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < xcr_pkg::ERR_KINDS; k++) begin
        err_cnt_r[k] <= err_cnt_nxt[k];
      end
      if (cfg_we && (cfg_index < xcr_pkg::CFG_IDX_W'(xcr_pkg::ERR_KINDS))) begin
        lim_r[cfg_index] <= cfg_wdata;
      end
    end
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire
